// File: design/nb2_pkg.sv
// Shared types and constants of the base-2 Niederreiter point generator.
`timescale 1ns / 1ps

package nb2_pkg;

	localparam int MAX_DIMS_DEF  = 32;
	localparam int WORD_BITS_DEF = 31;
	localparam int CFG_W         = 6;
	localparam int DIMOUT_W      = 5;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_NEXT  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic done;
		logic exhausted;
	} scan_rsp_t;

endpackage

// File: design/niederreiter_base2_point_generator.sv
// Top level of the base-2 Niederreiter quasi-random point generator.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  in       | in_valid / in_ready        | operation, dimension_index, bit_column,
//           |                            | direction_word, skip_count
//  out      | out_valid / out_ready      | coordinate, coordinate_dimension,
//           |                            | last_of_point, status
//  config   | dimensions_in_use_we       | dimensions_in_use
//
// Load writes one table word. Start walks all columns of n = dimensions in use:
// one direction word is read from the single-port table each cycle and XORed in
// when that bit of the Gray code of skip_count is set. Next scans the counter for
// its lowest clear bit, then emits n words, one per cycle while out_ready allows,
// each updated by a table write-back unless the counter is exhausted.
// Reset clears current words, the counter and the dimension count (to 1); the
// direction table is not cleared. Output stalls hold the emit step in place.
`timescale 1ns / 1ps

module niederreiter_base2_point_generator
	import nb2_pkg::*;
#(
	parameter int MAX_DIMS  = MAX_DIMS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  dimensions_in_use_we,
	input  logic [CFG_W-1:0]      dimensions_in_use,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            operation,
	input  logic [4:0]            dimension_index,
	input  logic [4:0]            bit_column,
	input  logic [WORD_BITS-1:0]  direction_word,
	input  logic [WORD_BITS-1:0]  skip_count,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WORD_BITS-1:0]  coordinate,
	output logic [DIMOUT_W-1:0]   coordinate_dimension,
	output logic                  last_of_point,
	output logic                  status
);

	localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CW    = $clog2(WORD_BITS);
	localparam int RW    = $clog2(WORD_BITS + 1);
	localparam int DEPTH = MAX_DIMS * WORD_BITS;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = CFG_W + 1;

	// direction table, one word per dimension and bit column
	logic [WORD_BITS-1:0] tbl_mem [DEPTH];
	logic [WORD_BITS-1:0] rd_data_q;

	logic [WORD_BITS-1:0] cw_q [MAX_DIMS];
	logic [WORD_BITS-1:0] counter_q;
	logic [WORD_BITS-1:0] gray_q;
	logic [CFG_W-1:0]     dims_q;

	state_t               state_q, state_d;
	logic [DIM_W-1:0]     d_q;
	logic [CW-1:0]        r_q;
	logic [CW-1:0]        col_q;
	logic                 exh_q;

	logic                 pend_q;
	logic                 pend_use_q;
	logic                 pend_first_q;
	logic [DIM_W-1:0]     pend_dim_q;

	logic                 out_valid_q;
	logic [WORD_BITS-1:0] coord_q;
	logic [DIMOUT_W-1:0]  cdim_q;
	logic                 last_q;
	logic                 status_q;

	logic                 accept;
	logic                 load_ok;
	logic                 tbl_we;
	logic [AW-1:0]        wr_addr;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [CW-1:0]        rd_col;
	logic                 issue;
	logic                 issue_use;
	logic                 issue_first;
	logic                 out_load;
	logic                 scan_start;
	logic                 d_last;
	logic [NW-1:0]        n_ext;
	logic [DIM_W-1:0]     last_dim;
	scan_rsp_t            scan_rsp;
	logic [RW-1:0]        scan_col;

	nb2_scan #(
		.WORD_BITS(WORD_BITS)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scan_start),
		.word  (counter_q),
		.rsp   (scan_rsp),
		.col   (scan_col)
	);

	// zero acts as one, above MAX_DIMS acts as MAX_DIMS
	always_comb begin
		n_ext = NW'(dims_q);
		if (n_ext == '0) begin
			n_ext = NW'(1);
		end
		if (n_ext > NW'(MAX_DIMS)) begin
			n_ext = NW'(MAX_DIMS);
		end
		last_dim = DIM_W'(n_ext - NW'(1));
	end

	assign d_last  = (d_q == last_dim);
	assign accept  = in_valid && in_ready;
	assign load_ok = (NW'(dimension_index) < NW'(MAX_DIMS)) &&
	                 (NW'(bit_column) < NW'(WORD_BITS));
	assign wr_addr = AW'(AW'(DIM_W'(dimension_index)) * AW'(WORD_BITS)) +
	                 AW'(CW'(bit_column));
	assign rd_col  = (state_q == ST_EMIT) ? col_q : r_q;
	assign rd_addr = AW'(AW'(d_q) * AW'(WORD_BITS)) + AW'(rd_col);

	always_comb begin
		state_d     = state_q;
		in_ready    = (state_q == ST_IDLE) && !pend_q;
		tbl_we      = 1'b0;
		rd_en       = 1'b0;
		issue       = 1'b0;
		issue_use   = 1'b0;
		issue_first = 1'b0;
		out_load    = 1'b0;
		scan_start  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (operation)
						OP_LOAD:  tbl_we = load_ok;
						OP_START: state_d = ST_START;
						OP_NEXT: begin
							scan_start = 1'b1;
							state_d    = ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_START: begin
				rd_en       = 1'b1;
				issue       = 1'b1;
				issue_use   = gray_q[r_q];
				issue_first = (r_q == '0);
				if (r_q == CW'(WORD_BITS - 1) && d_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (scan_rsp.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// hold while the output word is still waiting
				if (!out_valid_q || out_ready) begin
					out_load  = 1'b1;
					rd_en     = !exh_q;
					issue     = !exh_q;
					issue_use = 1'b1;
					if (d_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[wr_addr] <= direction_word;
		end
		if (rd_en) begin
			rd_data_q <= tbl_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q       <= CFG_W'(1);
			counter_q    <= '0;
			gray_q       <= '0;
			d_q          <= '0;
			r_q          <= '0;
			col_q        <= '0;
			exh_q        <= 1'b0;
			pend_q       <= 1'b0;
			pend_use_q   <= 1'b0;
			pend_first_q <= 1'b0;
			pend_dim_q   <= '0;
		end else begin
			if (dimensions_in_use_we) begin
				dims_q <= dimensions_in_use;
			end
			pend_q       <= issue;
			pend_use_q   <= issue_use;
			pend_first_q <= issue_first;
			pend_dim_q   <= d_q;
			if (accept && operation == OP_START) begin
				gray_q    <= skip_count ^ (skip_count >> 1);
				counter_q <= skip_count;
				d_q       <= '0;
				r_q       <= '0;
			end
			if (state_q == ST_START) begin
				if (r_q == CW'(WORD_BITS - 1)) begin
					r_q <= '0;
					d_q <= d_q + DIM_W'(1);
				end else begin
					r_q <= r_q + CW'(1);
				end
			end
			if (state_q == ST_SCAN && scan_rsp.done) begin
				col_q <= CW'(scan_col);
				exh_q <= scan_rsp.exhausted;
				d_q   <= '0;
			end
			if (out_load) begin
				d_q <= d_q + DIM_W'(1);
				if (d_last && !exh_q) begin
					counter_q <= counter_q + WORD_BITS'(1);
				end
			end
		end
	end

	// write back one accumulated word per cycle, in the cycle after its table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIMS; i++) begin
				cw_q[i] <= '0;
			end
		end else if (pend_q) begin
			cw_q[pend_dim_q] <= (pend_first_q ? '0 : cw_q[pend_dim_q]) ^
			                    (pend_use_q ? rd_data_q : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			coord_q  <= cw_q[d_q];
			cdim_q   <= DIMOUT_W'(d_q);
			last_q   <= d_last;
			status_q <= exh_q;
		end
	end

	assign out_valid            = out_valid_q;
	assign coordinate           = coord_q;
	assign coordinate_dimension = cdim_q;
	assign last_of_point        = last_q;
	assign status               = status_q;

endmodule

// File: design/nb2_scan.sv
// Iterative lowest-zero-bit finder for the point counter.
`timescale 1ns / 1ps

module nb2_scan
	import nb2_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [WORD_BITS-1:0]     word,
	output scan_rsp_t                rsp,
	output logic [$clog2(WORD_BITS+1)-1:0] col
);

	localparam int RW = $clog2(WORD_BITS + 1);
	localparam int CW = $clog2(WORD_BITS);

	logic          busy_q;
	logic [RW-1:0] col_q;
	logic          at_end;
	logic          bit_set;

	assign at_end  = (col_q == RW'(WORD_BITS));
	assign bit_set = at_end ? 1'b0 : word[col_q[CW-1:0]];

	assign rsp.done      = busy_q && !bit_set;
	assign rsp.exhausted = at_end;
	assign col           = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			col_q  <= '0;
		end else if (busy_q) begin
			// advance past each set bit, stop at the first clear one
			if (bit_set) begin
				col_q <= col_q + RW'(1);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule
